[sv/gfer_pkg.sv]
// shared types, constants and GF(2^8) multiply for the erasure reconstruct unit
package gfer_pkg;

	localparam int DATA_CELLS_DEF = 10;
	localparam int MAX_LOST_DEF   = 4;
	localparam int BYTE_LANES_DEF = 8;

	localparam int COEF_WORDS  = 5;
	localparam int COEF_BYTES  = COEF_WORDS * 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ERASURE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_FIRST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_LAST     = 3'd6;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  slot_index;
	} in_item_t;

	typedef struct packed {
		logic [63:0] recovered_word;
		logic [1:0]  erasure_rank;
		logic        last_of_run;
	} out_item_t;

	typedef struct packed {
		logic       first;
		logic       last;
		logic [3:0] lost;
		logic [7:0] poly;
	} gfer_ctl_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] t;
		logic [7:0] r;
		t = b;
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (a[i]) begin
				r = r ^ t;
			end
			t = t[7] ? ({t[6:0], 1'b0} ^ poly) : {t[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[sv/gf256_erasure_reconstruct_unit.sv]
// top level of the GF(2^8) erasure reconstruct unit
//
// Input channel (item_valid / item_stall / item): one 64-bit word of one
// surviving cell per item, cells 0 to DATA_CELLS-1 in order for each word
// position. Items with a cell index of DATA_CELLS or more are taken and dropped.
// Output channel (result_valid / result_stall / result): after the last cell
// of a position, one recovered word per erasure in rank order, the last
// one flagged with last_of_run.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata): always ready,
// written by the user only while the unit is idle; the unit does not check it.
// Throughput: one item and one result per cycle; item stall rises only when
// the four-entry queue in front of the multiply-accumulate stage is full and
// results hold while result_stall is high. A burst starts after its last cell
// is popped from the queue; the accumulate stage holds while a burst still
// drains and the next last cell arrives, and the queue absorbs the difference.
// Reset clears the accumulators, the queue and the registers (field
// polynomial to 0x1d). A stalled result holds until it is taken.
module gf256_erasure_reconstruct_unit #(
	parameter int DATA_CELLS = gfer_pkg::DATA_CELLS_DEF,
	parameter int MAX_LOST   = gfer_pkg::MAX_LOST_DEF,
	parameter int BYTE_LANES = gfer_pkg::BYTE_LANES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  gfer_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output gfer_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gfer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                     cfg_wdata
);
	import gfer_pkg::*;

	localparam int LW = 8 * BYTE_LANES;
	localparam int QW = $bits(gfer_ctl_t) + 8 * MAX_LOST + LW;
	localparam int CI_W = $clog2(COEF_WORDS);

	logic [2:0]                   erasure_count_q;
	logic [7:0]                   field_poly_q;
	logic [COEF_WORDS-1:0][63:0]  coef_q;

	logic                         keep;
	gfer_ctl_t                    f_ctl;
	logic [LW-1:0]                f_data;
	logic [MAX_LOST-1:0][7:0]     f_coefs;
	logic [QW-1:0]                push_word;
	logic [QW-1:0]                head;
	logic                         q_full;
	logic                         q_valid;
	logic                         q_pop;
	gfer_ctl_t                    b_ctl;
	logic [LW-1:0]                b_data;
	logic [MAX_LOST-1:0][7:0]     b_coefs;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erasure_count_q <= 3'd0;
			field_poly_q    <= 8'd29;
			coef_q          <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index) inside
				CFG_ERASURE_COUNT: erasure_count_q <= cfg_wdata[2:0];
				CFG_FIELD_POLY:    field_poly_q    <= cfg_wdata[7:0];
				[CFG_COEF_FIRST:CFG_COEF_LAST]: begin
					coef_q[CI_W'(cfg_index - CFG_COEF_FIRST)] <= cfg_wdata;
				end
				default: ;
			endcase
		end
	end

	gfer_front #(
		.DATA_CELLS (DATA_CELLS),
		.MAX_LOST   (MAX_LOST),
		.BYTE_LANES (BYTE_LANES)
	) u_front (
		.item          (item),
		.coef_words    (coef_q),
		.erasure_count (erasure_count_q),
		.field_poly    (field_poly_q),
		.keep          (keep),
		.ctl           (f_ctl),
		.data          (f_data),
		.coefs         (f_coefs)
	);

	assign push_word  = {f_ctl, f_coefs, f_data};
	assign item_stall = q_full;

	gfer_queue #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_valid & keep),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_valid),
		.head      (head)
	);

	assign {b_ctl, b_coefs, b_data} = head;

	gfer_back #(
		.MAX_LOST   (MAX_LOST),
		.BYTE_LANES (BYTE_LANES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.ctl          (b_ctl),
		.data         (b_data),
		.coefs        (b_coefs),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[sv/gfer_front.sv]
// front end: classifies each item and picks the coefficient byte of every rank
module gfer_front #(
	parameter int DATA_CELLS = gfer_pkg::DATA_CELLS_DEF,
	parameter int MAX_LOST   = gfer_pkg::MAX_LOST_DEF,
	parameter int BYTE_LANES = gfer_pkg::BYTE_LANES_DEF
) (
	input  gfer_pkg::in_item_t                                  item,
	input  logic [gfer_pkg::COEF_WORDS-1:0][63:0]               coef_words,
	input  logic [2:0]                                          erasure_count,
	input  logic [7:0]                                          field_poly,
	output logic                                                keep,
	output gfer_pkg::gfer_ctl_t                                 ctl,
	output logic [8*BYTE_LANES-1:0]                             data,
	output logic [MAX_LOST-1:0][7:0]                            coefs
);
	import gfer_pkg::*;

	logic [COEF_BYTES*8-1:0] coef_flat;
	logic [3:0]              count_ext;

	assign coef_flat = coef_words;
	assign count_ext = {1'b0, erasure_count};

	assign keep = 5'(item.slot_index) < 5'(DATA_CELLS);
	assign data = item.data_word[8*BYTE_LANES-1:0];

	assign ctl.first = item.slot_index == 4'd0;
	assign ctl.last  = item.slot_index == 4'(DATA_CELLS - 1);
	assign ctl.lost  = (count_ext > 4'(MAX_LOST)) ? 4'(MAX_LOST) : count_ext;
	assign ctl.poly  = field_poly;

	always_comb begin
		int bi;
		bi = 0;
		for (int r = 0; r < MAX_LOST; r++) begin
			coefs[r] = 8'h00;
			for (int c = 0; c < DATA_CELLS; c++) begin
				bi = r * DATA_CELLS + c;
				if (item.slot_index == 4'(c) && bi < COEF_BYTES) begin
					coefs[r] = coef_flat[bi*8 +: 8];
				end
			end
		end
	end

endmodule

[sv/gfer_queue.sv]
// short fifo between the front end and the accumulate back end
module gfer_queue #(
	parameter int W     = 8,
	parameter int DEPTH = gfer_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_word,
	output logic         full,
	input  logic         pop,
	output logic         nonempty,
	output logic [W-1:0] head
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = cnt_q == CW'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = mem_q[rd_q];
	assign do_push  = push & ~full;
	assign do_pop   = pop & nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

[sv/gfer_back.sv]
// back end: gf multiply-accumulate per rank and the burst of recovered words
module gfer_back #(
	parameter int MAX_LOST   = gfer_pkg::MAX_LOST_DEF,
	parameter int BYTE_LANES = gfer_pkg::BYTE_LANES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  gfer_pkg::gfer_ctl_t           ctl,
	input  logic [8*BYTE_LANES-1:0]       data,
	input  logic [MAX_LOST-1:0][7:0]      coefs,
	output logic                          pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output gfer_pkg::out_item_t           result
);
	import gfer_pkg::*;

	localparam int LW    = 8 * BYTE_LANES;
	localparam int IDX_W = (MAX_LOST > 1) ? $clog2(MAX_LOST) : 1;
	localparam int CNT_W = $clog2(MAX_LOST + 1);

	logic [LW-1:0]    acc_q  [MAX_LOST];
	logic [LW-1:0]    snap_q [MAX_LOST];
	logic [LW-1:0]    acc_nxt[MAX_LOST];
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             hs;
	logic             at_end;
	logic             snap_free;
	logic             emit;
	logic [7:0]       rank_ext;

	assign hs        = busy_q & ~result_stall;
	assign at_end    = CNT_W'(idx_q) == (cnt_q - CNT_W'(1));
	assign snap_free = ~busy_q | (hs & at_end);
	assign emit      = ctl.last & (ctl.lost != 4'd0);
	assign pop       = q_valid & (~emit | snap_free);

	always_comb begin
		logic [LW-1:0] word;
		word = '0;
		for (int r = 0; r < MAX_LOST; r++) begin
			for (int l = 0; l < BYTE_LANES; l++) begin
				word[l*8 +: 8] = gf_mul(data[l*8 +: 8], coefs[r], ctl.poly);
			end
			acc_nxt[r] = ctl.first ? word : (acc_q[r] ^ word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_LOST; r++) begin
				acc_q[r] <= '0;
			end
		end else if (pop) begin
			for (int r = 0; r < MAX_LOST; r++) begin
				acc_q[r] <= acc_nxt[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			for (int r = 0; r < MAX_LOST; r++) begin
				snap_q[r] <= acc_nxt[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else if (pop && emit) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			cnt_q  <= CNT_W'(ctl.lost);
		end else if (hs) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign rank_ext              = 8'(idx_q);
	assign result_valid          = busy_q;
	assign result.recovered_word = 64'(snap_q[idx_q]);
	assign result.erasure_rank   = rank_ext[1:0];
	assign result.last_of_run    = at_end;

endmodule

[sv/gfer_checker.sv]
// port-level checks for the erasure reconstruct unit, bound to the top level
module gfer_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_stall,
	input gfer_pkg::out_item_t  result,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);
	import gfer_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.last_of_run |=>
		result_valid && result.erasure_rank == $past(result.erasure_rank) + 2'd1)
		else $error("burst broke before its last item");

	a_rank_restart: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && result.last_of_run |=>
		!result_valid || result.erasure_rank == 2'd0)
		else $error("new burst does not start at rank zero");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind gf256_erasure_reconstruct_unit gfer_checker u_gfer_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);
